// ===== sv/fts_pkg.sv =====
// shared types and constants of the frame timer
package fts_pkg;

  localparam int WORD_W     = 64;
  localparam int NOW_W      = 63;
  localparam int SUM_W      = 63;
  localparam int DELTA_W    = 32;
  localparam int FPS_W      = 32;
  localparam int ALPHA_W    = 17;
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int DIV_LO_W   = 16;
  localparam int QUOT_W     = 32;
  localparam int DIV_CNT_W  = 6;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DELTA  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FIXED_STEP = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TPS        = 2'd2;

  localparam logic [CFG_W-1:0] MAX_DELTA_RST  = 32'd2500000;
  localparam logic [CFG_W-1:0] FIXED_STEP_RST = 32'd0;
  localparam logic [CFG_W-1:0] TPS_RST        = 32'd10000000;

  localparam logic [WORD_W-1:0]  SAT63     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [FPS_W-1:0]   SAT32     = 32'hFFFF_FFFF;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h1_0000;

  localparam logic [DIV_CNT_W-1:0] DIV_ITERS_FPS   = 6'd32;
  localparam logic [DIV_CNT_W-1:0] DIV_ITERS_ALPHA = 6'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TSUB,
    ST_TADD,
    ST_TMUL,
    ST_TCHK,
    ST_TDIV,
    ST_STEP,
    ST_ALPHA,
    ST_ADIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic long_div;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// ===== sv/fts_in_if.sv =====
// input item channel: command and counter value
interface fts_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [fts_pkg::NOW_W-1:0]  now_ticks;

  modport source (output valid, output cmd, output now_ticks, input ready);
  modport sink   (input valid, input cmd, input now_ticks, output ready);
endinterface

// ===== sv/fts_out_if.sv =====
// result item channel
interface fts_out_if;
  logic                         valid;
  logic                         ready;
  logic [fts_pkg::DELTA_W-1:0]  delta_ticks;
  logic [fts_pkg::SUM_W-1:0]    total_ticks;
  logic [fts_pkg::SUM_W-1:0]    fixed_time_ticks;
  logic                         step_taken;
  logic [fts_pkg::FPS_W-1:0]    fps_q16;
  logic                         fps_updated;
  logic [fts_pkg::ALPHA_W-1:0]  alpha_q16;

  modport source (output valid, output delta_ticks, output total_ticks,
                  output fixed_time_ticks, output step_taken, output fps_q16,
                  output fps_updated, output alpha_q16, input ready);
  modport sink   (input valid, input delta_ticks, input total_ticks,
                  input fixed_time_ticks, input step_taken, input fps_q16,
                  input fps_updated, input alpha_q16, output ready);
endinterface

// ===== sv/fts_cfg_if.sv =====
// configuration write channel
interface fts_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fts_pkg::CFG_ADDR_W-1:0]  addr;
  logic [fts_pkg::CFG_W-1:0]       data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== sv/fts_div.sv =====
// restoring divider, one quotient bit per cycle
module fts_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fts_pkg::div_req_t                 req,
  input  logic [fts_pkg::SUM_W-1:0]         num_hi,
  input  logic [fts_pkg::DIV_LO_W-1:0]      num_lo,
  input  logic [fts_pkg::SUM_W-1:0]         den,
  output fts_pkg::div_rsp_t                 rsp,
  output logic [fts_pkg::QUOT_W-1:0]        quot
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [fts_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [fts_pkg::SUM_W-1:0]         rem_r, rem_nxt;
  logic [fts_pkg::DIV_LO_W-1:0]      low_r, low_nxt;
  logic [fts_pkg::SUM_W-1:0]         den_r, den_nxt;
  logic [fts_pkg::QUOT_W-1:0]        q_r, q_nxt;

  logic [fts_pkg::WORD_W-1:0]        rem2;
  logic [fts_pkg::WORD_W-1:0]        den2;
  logic [fts_pkg::WORD_W-1:0]        diff;
  logic                              ge;

  // partial remainder stays below the divisor, so the shifted one fits 64 bits
  assign rem2 = {rem_r, low_r[fts_pkg::DIV_LO_W-1]};
  assign den2 = {1'b0, den_r};
  assign ge   = rem2 >= den2;
  assign diff = rem2 - den2;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.long_div ? fts_pkg::DIV_ITERS_FPS : fts_pkg::DIV_ITERS_ALPHA;
      rem_nxt  = num_hi;
      low_nxt  = num_lo;
      den_nxt  = den;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[fts_pkg::SUM_W-1:0] : rem2[fts_pkg::SUM_W-1:0];
      low_nxt = {low_r[fts_pkg::DIV_LO_W-2:0], 1'b0};
      q_nxt   = {q_r[fts_pkg::QUOT_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == fts_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quot     = q_r;

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("divider did not start");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == fts_pkg::DIV_CNT_W'(1)) |=> (done_r && !busy_r))
    else $error("divider missed its done pulse");
`endif

endmodule

// ===== sv/frame_timer_fixed_step.sv =====
// frame timer: bit-sliced tick arithmetic, q16 fps and alpha through a serial divider
// sequence: two digit passes on a frame tick (subtract, add), one on a step request; then
//   the alpha divide unless the step is zero or a full one is left; a tick that closes the
//   window adds a multiply, an overflow check and the fps divide (skipped on overflow)
// throughput: one item at a time; a new item is taken once the result is registered
// reset: synchronous rst_n clears all timing state and loads the register defaults

module frame_timer_fixed_step #(
  parameter int DIGIT_W = 8  // digit width of the serial passes, power of two 1 to 32
) (
  input  logic        clk,
  input  logic        rst_n,
  fts_in_if.sink      in_ch,
  fts_out_if.source   out_ch,
  fts_cfg_if.sink     cfg_ch
);

  localparam int NDIG  = fts_pkg::WORD_W / DIGIT_W;
  localparam int CNT_W = $clog2(NDIG);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NDIG - 1);
  localparam int W = fts_pkg::WORD_W;

  fts_pkg::state_t state_r, state_nxt;

  // configuration
  logic [fts_pkg::CFG_W-1:0] max_delta_r, fixed_step_r, tps_r;

  // timing state, 64-bit words rotated one digit per cycle
  logic                  started_r, started_nxt;
  logic [W-1:0]          last_r, last_nxt;
  logic [W-1:0]          total_r, total_nxt;
  logic [W-1:0]          fixed_r, fixed_nxt;
  logic [W-1:0]          acc_r, acc_nxt;
  logic [W-1:0]          win_r, win_nxt;
  logic [fts_pkg::CFG_W-1:0]   fc_r, fc_nxt;
  logic [fts_pkg::FPS_W-1:0]   fps_r, fps_nxt;
  logic                  updated_r, updated_nxt;
  logic [fts_pkg::DELTA_W-1:0] delta_r, delta_nxt;

  // sequencing and per-item scratch
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt;
  logic                  f0_r, f0_nxt, f1_r, f1_nxt;
  logic                  taken_r, taken_nxt;
  logic                  age_r, age_nxt;
  logic [fts_pkg::ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [W-1:0]          now_r, now_nxt;
  logic [W-1:0]          sh_a_r, sh_a_nxt;
  logic [W-1:0]          sh_b_r, sh_b_nxt;
  logic [W-1:0]          num_r, num_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic                  load_out;
  logic [fts_pkg::DELTA_W-1:0] o_delta_r;
  logic [fts_pkg::SUM_W-1:0]   o_total_r, o_fixed_r;
  logic                  o_taken_r, o_updated_r;
  logic [fts_pkg::FPS_W-1:0]   o_fps_r;
  logic [fts_pkg::ALPHA_W-1:0] o_alpha_r;

  // divider
  fts_pkg::div_req_t          div_req;
  fts_pkg::div_rsp_t          div_rsp;
  logic [fts_pkg::SUM_W-1:0]  div_num_hi, div_den;
  logic [fts_pkg::DIV_LO_W-1:0] div_num_lo;
  logic [fts_pkg::QUOT_W-1:0] div_quot;

  // digit slice
  logic [fts_pkg::CFG_W-1:0] tps_eff;
  logic [W-1:0]          max_ext, fix_ext, fix2_ext, tps_ext, dl_ext;
  logic [DIGIT_W-1:0]    max_dig, fix_dig, fix2_dig, tps_dig, dl_dig;
  logic [DIGIT_W-1:0]    now_dig, prev_dig, acc_dig;
  logic [DIGIT_W:0]      sub_t, sub_s, add_t, add_a, add_w, add_f;
  logic [W-1:0]          diff_full;
  logic                  last_dig, gt_n, wge_n, age_n, ge2_n;
  logic                  wge_fin, ovf, take, fix_zero, in_xfer;

  assign tps_eff  = (tps_r == '0) ? fts_pkg::CFG_W'(1) : tps_r;
  assign max_ext  = {32'b0, max_delta_r};
  assign fix_ext  = {32'b0, fixed_step_r};
  assign fix2_ext = {31'b0, fixed_step_r, 1'b0};
  assign tps_ext  = {32'b0, tps_eff};
  assign dl_ext   = {32'b0, delta_r};
  assign fix_zero = (fixed_step_r == '0);
  assign last_dig = (cnt_r == CNT_LAST);
  assign in_xfer  = in_ch.valid && in_ch.ready;

  always_comb begin
    max_dig  = max_ext[cnt_r*DIGIT_W +: DIGIT_W];
    fix_dig  = fix_ext[cnt_r*DIGIT_W +: DIGIT_W];
    fix2_dig = fix2_ext[cnt_r*DIGIT_W +: DIGIT_W];
    tps_dig  = tps_ext[cnt_r*DIGIT_W +: DIGIT_W];
    dl_dig   = dl_ext[cnt_r*DIGIT_W +: DIGIT_W];
    now_dig  = now_r[DIGIT_W-1:0];
    // before the first tick the previous count reads as the new one
    prev_dig = started_r ? last_r[DIGIT_W-1:0] : now_dig;
    acc_dig  = acc_r[DIGIT_W-1:0];

    sub_t = {1'b0, now_dig} - {1'b0, prev_dig} - {{DIGIT_W{1'b0}}, c0_r};
    sub_s = {1'b0, acc_dig} - {1'b0, fix_dig} - {{DIGIT_W{1'b0}}, c0_r};
    add_t = {1'b0, total_r[DIGIT_W-1:0]} + {1'b0, dl_dig} + {{DIGIT_W{1'b0}}, c0_r};
    add_a = {1'b0, acc_dig} + {1'b0, dl_dig} + {{DIGIT_W{1'b0}}, c1_r};
    add_w = {1'b0, win_r[DIGIT_W-1:0]} + {1'b0, dl_dig} + {{DIGIT_W{1'b0}}, c2_r};
    add_f = {1'b0, fixed_r[DIGIT_W-1:0]} + {1'b0, fix_dig} + {{DIGIT_W{1'b0}}, c1_r};

    diff_full = {sub_t[DIGIT_W-1:0], sh_a_r[W-1:DIGIT_W]};

    // lsb-first magnitude compares, decided by the most significant digit seen
    gt_n  = (sub_t[DIGIT_W-1:0] > max_dig) || ((sub_t[DIGIT_W-1:0] == max_dig) && f0_r);
    wge_n = (add_w[DIGIT_W-1:0] > tps_dig) || ((add_w[DIGIT_W-1:0] == tps_dig) && f0_r);
    age_n = (add_a[DIGIT_W-1:0] > fix_dig) || ((add_a[DIGIT_W-1:0] == fix_dig) && f1_r);
    ge2_n = (acc_dig > fix2_dig) || ((acc_dig == fix2_dig) && f1_r);

    // a saturated window is always past one second
    wge_fin = add_w[DIGIT_W-1] || wge_n;
    ovf     = {15'b0, num_r[W-1:fts_pkg::DIV_LO_W]} >= win_r[fts_pkg::SUM_W-1:0];
    take    = !fix_zero && !sub_s[DIGIT_W];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fts_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.cmd == fts_pkg::CMD_STEP) ? fts_pkg::ST_STEP : fts_pkg::ST_TSUB;
        end
      end
      fts_pkg::ST_TSUB: begin
        if (last_dig) state_nxt = fts_pkg::ST_TADD;
      end
      fts_pkg::ST_TADD: begin
        if (last_dig) state_nxt = wge_fin ? fts_pkg::ST_TMUL : fts_pkg::ST_ALPHA;
      end
      fts_pkg::ST_TMUL: state_nxt = fts_pkg::ST_TCHK;
      fts_pkg::ST_TCHK: state_nxt = ovf ? fts_pkg::ST_ALPHA : fts_pkg::ST_TDIV;
      fts_pkg::ST_TDIV: begin
        if (div_rsp.done) state_nxt = fts_pkg::ST_ALPHA;
      end
      fts_pkg::ST_STEP: begin
        if (last_dig) state_nxt = fts_pkg::ST_ALPHA;
      end
      fts_pkg::ST_ALPHA: begin
        state_nxt = (fix_zero || age_r) ? fts_pkg::ST_DONE : fts_pkg::ST_ADIV;
      end
      fts_pkg::ST_ADIV: begin
        if (div_rsp.done) state_nxt = fts_pkg::ST_DONE;
      end
      fts_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = fts_pkg::ST_IDLE;
      end
      default: state_nxt = fts_pkg::ST_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    started_nxt = started_r;
    last_nxt    = last_r;
    total_nxt   = total_r;
    fixed_nxt   = fixed_r;
    acc_nxt     = acc_r;
    win_nxt     = win_r;
    fc_nxt      = fc_r;
    fps_nxt     = fps_r;
    updated_nxt = updated_r;
    delta_nxt   = delta_r;
    cnt_nxt     = cnt_r;
    c0_nxt      = c0_r;
    c1_nxt      = c1_r;
    c2_nxt      = c2_r;
    f0_nxt      = f0_r;
    f1_nxt      = f1_r;
    taken_nxt   = taken_r;
    age_nxt     = age_r;
    alpha_nxt   = alpha_r;
    now_nxt     = now_r;
    sh_a_nxt    = sh_a_r;
    sh_b_nxt    = sh_b_r;
    num_nxt     = num_r;
    load_out    = 1'b0;
    div_req     = '0;
    div_num_hi  = acc_r[fts_pkg::SUM_W-1:0];
    div_num_lo  = '0;
    div_den     = {31'b0, fixed_step_r};

    case (state_r)
      fts_pkg::ST_IDLE: begin
        if (in_xfer) begin
          now_nxt   = {1'b0, in_ch.now_ticks};
          cnt_nxt   = '0;
          c0_nxt    = 1'b0;
          c1_nxt    = 1'b0;
          c2_nxt    = 1'b0;
          f0_nxt    = 1'b0;
          f1_nxt    = 1'b1;
          taken_nxt = 1'b0;
        end
      end
      fts_pkg::ST_TSUB: begin
        now_nxt  = {now_dig, now_r[W-1:DIGIT_W]};
        last_nxt = {now_dig, last_r[W-1:DIGIT_W]};
        sh_a_nxt = diff_full;
        c0_nxt   = sub_t[DIGIT_W];
        f0_nxt   = gt_n;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_dig) begin
          // counter moved back gives zero, a delta above the maximum is clamped to it
          if (sub_t[DIGIT_W]) delta_nxt = '0;
          else if (gt_n)      delta_nxt = max_delta_r;
          else                delta_nxt = diff_full[fts_pkg::DELTA_W-1:0];
          started_nxt = 1'b1;
          c0_nxt = 1'b0;
          c1_nxt = 1'b0;
          c2_nxt = 1'b0;
          f0_nxt = 1'b1;
          f1_nxt = 1'b1;
        end
      end
      fts_pkg::ST_TADD: begin
        total_nxt = {add_t[DIGIT_W-1:0], total_r[W-1:DIGIT_W]};
        acc_nxt   = {add_a[DIGIT_W-1:0], acc_r[W-1:DIGIT_W]};
        win_nxt   = {add_w[DIGIT_W-1:0], win_r[W-1:DIGIT_W]};
        c0_nxt    = add_t[DIGIT_W];
        c1_nxt    = add_a[DIGIT_W];
        c2_nxt    = add_w[DIGIT_W];
        f0_nxt    = wge_n;
        f1_nxt    = age_n;
        cnt_nxt   = cnt_r + 1'b1;
        if (last_dig) begin
          if (add_t[DIGIT_W-1]) total_nxt = fts_pkg::SAT63;
          if (add_a[DIGIT_W-1]) acc_nxt   = fts_pkg::SAT63;
          if (add_w[DIGIT_W-1]) win_nxt   = fts_pkg::SAT63;
          age_nxt     = add_a[DIGIT_W-1] || age_n;
          fc_nxt      = (fc_r == fts_pkg::SAT32) ? fc_r : fc_r + 1'b1;
          updated_nxt = 1'b0;
        end
      end
      fts_pkg::ST_TMUL: begin
        num_nxt = fc_r * tps_eff;
        fc_nxt  = '0;
      end
      fts_pkg::ST_TCHK: begin
        win_nxt = '0;
        if (ovf) begin
          fps_nxt     = fts_pkg::SAT32;
          updated_nxt = 1'b1;
        end else begin
          div_req.start    = 1'b1;
          div_req.long_div = 1'b1;
          div_num_hi       = {15'b0, num_r[W-1:fts_pkg::DIV_LO_W]};
          div_num_lo       = num_r[fts_pkg::DIV_LO_W-1:0];
          div_den          = win_r[fts_pkg::SUM_W-1:0];
        end
      end
      fts_pkg::ST_TDIV: begin
        if (div_rsp.done) begin
          fps_nxt     = div_quot;
          updated_nxt = 1'b1;
        end
      end
      fts_pkg::ST_STEP: begin
        acc_nxt   = {acc_dig, acc_r[W-1:DIGIT_W]};
        fixed_nxt = {fixed_r[DIGIT_W-1:0], fixed_r[W-1:DIGIT_W]};
        sh_a_nxt  = {sub_s[DIGIT_W-1:0], sh_a_r[W-1:DIGIT_W]};
        sh_b_nxt  = {add_f[DIGIT_W-1:0], sh_b_r[W-1:DIGIT_W]};
        c0_nxt    = sub_s[DIGIT_W];
        c1_nxt    = add_f[DIGIT_W];
        f1_nxt    = ge2_n;
        cnt_nxt   = cnt_r + 1'b1;
        if (last_dig) begin
          taken_nxt = take;
          // after the step the accumulator still holds a full step when it held two
          age_nxt   = take && ge2_n;
          if (take) begin
            acc_nxt   = sh_a_nxt;
            fixed_nxt = add_f[DIGIT_W-1] ? fts_pkg::SAT63 : sh_b_nxt;
          end
        end
      end
      fts_pkg::ST_ALPHA: begin
        if (fix_zero) begin
          alpha_nxt = '0;
        end else if (age_r) begin
          alpha_nxt = fts_pkg::ALPHA_ONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.long_div = 1'b0;
        end
      end
      fts_pkg::ST_ADIV: begin
        if (div_rsp.done) alpha_nxt = {1'b0, div_quot[fts_pkg::DIV_LO_W-1:0]};
      end
      fts_pkg::ST_DONE: begin
        load_out = !out_valid_r || out_ch.ready;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase

    out_valid_nxt = load_out || (out_valid_r && !out_ch.ready);
  end

  assign in_ch.ready  = (state_r == fts_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  fts_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .num_hi (div_num_hi),
    .num_lo (div_num_lo),
    .den    (div_den),
    .rsp    (div_rsp),
    .quot   (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fts_pkg::ST_IDLE;
      max_delta_r  <= fts_pkg::MAX_DELTA_RST;
      fixed_step_r <= fts_pkg::FIXED_STEP_RST;
      tps_r        <= fts_pkg::TPS_RST;
      started_r    <= 1'b0;
      last_r       <= '0;
      total_r      <= '0;
      fixed_r      <= '0;
      acc_r        <= '0;
      win_r        <= '0;
      fc_r         <= '0;
      fps_r        <= '0;
      updated_r    <= 1'b0;
      delta_r      <= '0;
      cnt_r        <= '0;
      c0_r         <= 1'b0;
      c1_r         <= 1'b0;
      c2_r         <= 1'b0;
      f0_r         <= 1'b0;
      f1_r         <= 1'b0;
      taken_r      <= 1'b0;
      age_r        <= 1'b0;
      alpha_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          fts_pkg::REG_MAX_DELTA:  max_delta_r  <= cfg_ch.data;
          fts_pkg::REG_FIXED_STEP: fixed_step_r <= cfg_ch.data;
          fts_pkg::REG_TPS:        tps_r        <= cfg_ch.data;
          default: ;
        endcase
      end
      started_r    <= started_nxt;
      last_r       <= last_nxt;
      total_r      <= total_nxt;
      fixed_r      <= fixed_nxt;
      acc_r        <= acc_nxt;
      win_r        <= win_nxt;
      fc_r         <= fc_nxt;
      fps_r        <= fps_nxt;
      updated_r    <= updated_nxt;
      delta_r      <= delta_nxt;
      cnt_r        <= cnt_nxt;
      c0_r         <= c0_nxt;
      c1_r         <= c1_nxt;
      c2_r         <= c2_nxt;
      f0_r         <= f0_nxt;
      f1_r         <= f1_nxt;
      taken_r      <= taken_nxt;
      age_r        <= age_nxt;
      alpha_r      <= alpha_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    sh_a_r <= sh_a_nxt;
    sh_b_r <= sh_b_nxt;
    num_r  <= num_nxt;
    if (load_out) begin
      o_delta_r   <= delta_r;
      o_total_r   <= total_r[fts_pkg::SUM_W-1:0];
      o_fixed_r   <= fixed_r[fts_pkg::SUM_W-1:0];
      o_taken_r   <= taken_r;
      o_fps_r     <= fps_r;
      o_updated_r <= updated_r;
      o_alpha_r   <= alpha_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.delta_ticks      = o_delta_r;
  assign out_ch.total_ticks      = o_total_r;
  assign out_ch.fixed_time_ticks = o_fixed_r;
  assign out_ch.step_taken       = o_taken_r;
  assign out_ch.fps_q16          = o_fps_r;
  assign out_ch.fps_updated      = o_updated_r;
  assign out_ch.alpha_q16        = o_alpha_r;

`ifndef SYNTHESIS
  a_sums_63bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fts_pkg::ST_IDLE) |->
      (!total_r[W-1] && !acc_r[W-1] && !win_r[W-1] && !fixed_r[W-1]))
    else $error("saturating sum left its 63-bit range");

  a_step_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.cmd == fts_pkg::CMD_STEP) |=> (state_r == fts_pkg::ST_STEP))
    else $error("step request did not enter the step pass");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule
